// File: rtl/vstg_pkg.sv
package vstg_pkg;

    // Widths fixed by the register map and the result fields.
    localparam int REG_W = 11;
    localparam int IDX_W = 3;
    localparam int OUT_W = 12;
    localparam int SUM_W = REG_W + 2;

    localparam int COUNT_WIDTH_DEF = 12;

    // Register indexes.
    localparam logic [IDX_W-1:0] CFG_H_VISIBLE = 3'd0;
    localparam logic [IDX_W-1:0] CFG_H_FRONT   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_H_SYNC    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_H_BACK    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_V_VISIBLE = 3'd4;
    localparam logic [IDX_W-1:0] CFG_V_FRONT   = 3'd5;
    localparam logic [IDX_W-1:0] CFG_V_SYNC    = 3'd6;
    localparam logic [IDX_W-1:0] CFG_V_BACK    = 3'd7;

    // Reset values of the timing registers.
    localparam logic [REG_W-1:0] RST_H_VISIBLE = 11'd512;
    localparam logic [REG_W-1:0] RST_H_FRONT   = 11'd12;
    localparam logic [REG_W-1:0] RST_H_SYNC    = 11'd68;
    localparam logic [REG_W-1:0] RST_H_BACK    = 11'd80;
    localparam logic [REG_W-1:0] RST_V_VISIBLE = 11'd768;
    localparam logic [REG_W-1:0] RST_V_FRONT   = 11'd3;
    localparam logic [REG_W-1:0] RST_V_SYNC    = 11'd6;
    localparam logic [REG_W-1:0] RST_V_BACK    = 11'd29;

    typedef struct packed {
        logic [REG_W-1:0] h_visible;
        logic [REG_W-1:0] h_front;
        logic [REG_W-1:0] h_sync;
        logic [REG_W-1:0] h_back;
        logic [REG_W-1:0] v_visible;
        logic [REG_W-1:0] v_front;
        logic [REG_W-1:0] v_sync;
        logic [REG_W-1:0] v_back;
    } t_vstg_cfg;

    typedef struct packed {
        logic             hsync_n;
        logic             vsync_n;
        logic             visible;
        logic [OUT_W-1:0] column;
        logic [OUT_W-1:0] line;
    } t_vstg_pix;

endpackage

// File: rtl/vstg_cfg.sv
module vstg_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [vstg_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [vstg_pkg::REG_W-1:0] i_cfg_data,
    output vstg_pkg::t_vstg_cfg       o_cfg
);
    import vstg_pkg::*;

    t_vstg_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.h_visible <= RST_H_VISIBLE;
            r_cfg.h_front   <= RST_H_FRONT;
            r_cfg.h_sync    <= RST_H_SYNC;
            r_cfg.h_back    <= RST_H_BACK;
            r_cfg.v_visible <= RST_V_VISIBLE;
            r_cfg.v_front   <= RST_V_FRONT;
            r_cfg.v_sync    <= RST_V_SYNC;
            r_cfg.v_back    <= RST_V_BACK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_H_VISIBLE: r_cfg.h_visible <= i_cfg_data;
                CFG_H_FRONT:   r_cfg.h_front   <= i_cfg_data;
                CFG_H_SYNC:    r_cfg.h_sync    <= i_cfg_data;
                CFG_H_BACK:    r_cfg.h_back    <= i_cfg_data;
                CFG_V_VISIBLE: r_cfg.v_visible <= i_cfg_data;
                CFG_V_FRONT:   r_cfg.v_front   <= i_cfg_data;
                CFG_V_SYNC:    r_cfg.v_sync    <= i_cfg_data;
                CFG_V_BACK:    r_cfg.v_back    <= i_cfg_data;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/vstg_timing.sv
module vstg_timing #(
    parameter int COUNT_WIDTH = vstg_pkg::COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vstg_pkg::t_vstg_cfg i_cfg,
    input  logic                i_step,
    output vstg_pkg::t_vstg_pix o_pix
);
    import vstg_pkg::*;

    // Wide enough for a four-register sum and for the capped period.
    localparam int PW = (COUNT_WIDTH + 1 > SUM_W) ? COUNT_WIDTH + 1 : SUM_W;
    localparam logic [PW-1:0] LIMIT = PW'(1) << COUNT_WIDTH;

    logic [COUNT_WIDTH-1:0] r_col, n_col;
    logic [COUNT_WIDTH-1:0] r_line, n_line;

    logic [PW-1:0] h_total, v_total, h_per, v_per;
    logic [PW-1:0] col_ext, line_ext, col_inc, line_inc;
    logic [PW-1:0] h_start, h_end, v_start, v_end;
    logic          col_wrap, line_wrap, h_vis, v_vis;
    logic [OUT_W-1:0] col_out, line_out;

    assign h_total = PW'(i_cfg.h_visible) + PW'(i_cfg.h_front)
                   + PW'(i_cfg.h_sync) + PW'(i_cfg.h_back);
    assign v_total = PW'(i_cfg.v_visible) + PW'(i_cfg.v_front)
                   + PW'(i_cfg.v_sync) + PW'(i_cfg.v_back);
    assign h_per = (h_total > LIMIT) ? LIMIT : h_total;
    assign v_per = (v_total > LIMIT) ? LIMIT : v_total;

    assign col_ext  = PW'(r_col);
    assign line_ext = PW'(r_line);
    assign col_inc  = col_ext + PW'(1);
    assign line_inc = line_ext + PW'(1);
    // A counter left beyond a shortened period also wraps here.
    assign col_wrap  = col_inc >= h_per;
    assign line_wrap = line_inc >= v_per;

    assign h_start = PW'(i_cfg.h_sync) + PW'(i_cfg.h_back);
    assign h_end   = h_start + PW'(i_cfg.h_visible);
    assign v_start = PW'(i_cfg.v_sync) + PW'(i_cfg.v_back);
    assign v_end   = v_start + PW'(i_cfg.v_visible);
    assign h_vis   = (col_ext >= h_start) && (col_ext < h_end);
    assign v_vis   = (line_ext >= v_start) && (line_ext < v_end);

    always_comb begin
        n_col  = r_col;
        n_line = r_line;
        if (i_step) begin
            if (col_wrap) begin
                n_col  = '0;
                n_line = line_wrap ? '0 : line_inc[COUNT_WIDTH-1:0];
            end else begin
                n_col = col_inc[COUNT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= '0;
        end else begin
            r_col  <= n_col;
            r_line <= n_line;
        end
    end

    generate
        if (COUNT_WIDTH >= OUT_W) begin : g_trunc
            assign col_out  = r_col[OUT_W-1:0];
            assign line_out = r_line[OUT_W-1:0];
        end else begin : g_ext
            assign col_out  = {{(OUT_W - COUNT_WIDTH){1'b0}}, r_col};
            assign line_out = {{(OUT_W - COUNT_WIDTH){1'b0}}, r_line};
        end
    endgenerate

    assign o_pix.hsync_n = !(col_ext < PW'(i_cfg.h_sync));
    assign o_pix.vsync_n = !(line_ext < PW'(i_cfg.v_sync));
    assign o_pix.visible = h_vis && v_vis;
    assign o_pix.column  = col_out;
    assign o_pix.line    = line_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_col) && $stable(r_line)))
        else $error("counters moved without a step");

    a_col_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !col_wrap) |=> (r_col == $past(col_inc[COUNT_WIDTH-1:0])))
        else $error("column did not advance by one");

    a_line_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !col_wrap) |=> $stable(r_line))
        else $error("line moved while the column did not wrap");

endmodule

// File: rtl/video_sync_timing_generator.sv
// Raster timing generator: each input transfer is one pixel-clock tick and yields one
// result transfer with the sync, visible-area flag and column/line position of the
// current pixel; the counters then step one pixel when advance is set. A new tick is
// accepted every cycle: the result is computed from the counters and timing registers
// in one pass into a single output register, so the only pause comes from a stalled
// result that holds that register. Column 0 is the start of the horizontal sync pulse
// and line 0 the start of the vertical sync pulse; both syncs are active low. The user
// must write timing registers only while no result is pending; this is not enforced.
module video_sync_timing_generator #(
    parameter int COUNT_WIDTH = vstg_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [vstg_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [vstg_pkg::REG_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_advance,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_hsync_n,
    output logic                       o_vsync_n,
    output logic                       o_visible,
    output logic [vstg_pkg::OUT_W-1:0] o_column,
    output logic [vstg_pkg::OUT_W-1:0] o_line
);
    import vstg_pkg::*;

    t_vstg_cfg cfg;
    t_vstg_pix pix;
    t_vstg_pix r_pix;
    logic      r_out_valid;
    logic      accept;

    vstg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    vstg_timing #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_timing (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (accept && i_advance),
        .o_pix   (pix)
    );

    // A new tick may enter whenever the output register is empty or drains this cycle.
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= pix;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_hsync_n = r_pix.hsync_n;
    assign o_vsync_n = r_pix.vsync_n;
    assign o_visible = r_pix.visible;
    assign o_column  = r_pix.column;
    assign o_line    = r_pix.line;

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted tick produced no result");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_stall && !i_valid) |=> !r_out_valid)
        else $error("delivered result was repeated");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> ($stable(r_pix) && r_out_valid))
        else $error("pending result was overwritten");

endmodule

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vstg_pkg::*;

    localparam int CNT_LIMIT   = 1 << COUNT_WIDTH_DEF;
    localparam int STUCK_LIMIT = 2000;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_TICKS = 120;

    // Predicts the raster position and sync flags of every accepted tick and
    // holds the pixels still owed by the block.
    class raster_scoreboard;
        t_vstg_cfg timing;
        int        col_pos;
        int        line_pos;
        t_vstg_pix pixel_q[$];
        int        fails;

        function new();
            timing = '{h_visible: RST_H_VISIBLE, h_front: RST_H_FRONT,
                       h_sync: RST_H_SYNC, h_back: RST_H_BACK,
                       v_visible: RST_V_VISIBLE, v_front: RST_V_FRONT,
                       v_sync: RST_V_SYNC, v_back: RST_V_BACK};
            col_pos  = 0;
            line_pos = 0;
            fails    = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
            case (idx)
                CFG_H_VISIBLE: timing.h_visible = data;
                CFG_H_FRONT:   timing.h_front   = data;
                CFG_H_SYNC:    timing.h_sync    = data;
                CFG_H_BACK:    timing.h_back    = data;
                CFG_V_VISIBLE: timing.v_visible = data;
                CFG_V_FRONT:   timing.v_front   = data;
                CFG_V_SYNC:    timing.v_sync    = data;
                CFG_V_BACK:    timing.v_back    = data;
                default: ;
            endcase
        endfunction

        function int pending_count();
            return pixel_q.size();
        endfunction

        function void note_tick(bit adv);
            int        hv, hf, hs, hb, vv, vf, vs, vb;
            int        h_period, v_period;
            bit        h_in, v_in;
            t_vstg_pix px;
            hv = timing.h_visible;
            hf = timing.h_front;
            hs = timing.h_sync;
            hb = timing.h_back;
            vv = timing.v_visible;
            vf = timing.v_front;
            vs = timing.v_sync;
            vb = timing.v_back;
            h_period = hv + hf + hs + hb;
            v_period = vv + vf + vs + vb;
            // A period longer than the counter can hold wraps at the counter range.
            if (h_period > CNT_LIMIT) h_period = CNT_LIMIT;
            if (v_period > CNT_LIMIT) v_period = CNT_LIMIT;

            h_in = (col_pos >= hs + hb) && (col_pos < hs + hb + hv);
            v_in = (line_pos >= vs + vb) && (line_pos < vs + vb + vv);
            px.hsync_n = (col_pos < hs) ? 1'b0 : 1'b1;
            px.vsync_n = (line_pos < vs) ? 1'b0 : 1'b1;
            px.visible = h_in && v_in;
            px.column  = col_pos[OUT_W-1:0];
            px.line    = line_pos[OUT_W-1:0];
            pixel_q.push_back(px);

            if (adv) begin
                if (col_pos + 1 >= h_period) begin
                    col_pos = 0;
                    if (line_pos + 1 >= v_period) line_pos = 0;
                    else line_pos = line_pos + 1;
                end else begin
                    col_pos = col_pos + 1;
                end
            end
        endfunction

        function void check_pixel(t_vstg_pix got);
            t_vstg_pix want;
            if (pixel_q.size() == 0) begin
                $error("pixel transfer with no tick outstanding");
                fails++;
                return;
            end
            want = pixel_q.pop_front();
            if (got.hsync_n !== want.hsync_n) begin
                $error("hsync_n: expected %0d, actual %0d", want.hsync_n, got.hsync_n);
                fails++;
            end
            if (got.vsync_n !== want.vsync_n) begin
                $error("vsync_n: expected %0d, actual %0d", want.vsync_n, got.vsync_n);
                fails++;
            end
            if (got.visible !== want.visible) begin
                $error("visible: expected %0d, actual %0d", want.visible, got.visible);
                fails++;
            end
            if (got.column !== want.column) begin
                $error("column: expected %0d, actual %0d", want.column, got.column);
                fails++;
            end
            if (got.line !== want.line) begin
                $error("line: expected %0d, actual %0d", want.line, got.line);
                fails++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [REG_W-1:0] i_cfg_data;
    logic             i_valid;
    logic             o_stall;
    logic             i_advance;
    logic             o_valid;
    logic             i_stall;
    logic             o_hsync_n;
    logic             o_vsync_n;
    logic             o_visible;
    logic [OUT_W-1:0] o_column;
    logic [OUT_W-1:0] o_line;

    raster_scoreboard sb = new();

    int send_gap_pct;
    int recv_gap_pct;
    int hold_left;
    int stuck_cycles;

    video_sync_timing_generator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_advance  (i_advance),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_hsync_n  (o_hsync_n),
        .o_vsync_n  (o_vsync_n),
        .o_visible  (o_visible),
        .o_column   (o_column),
        .o_line     (o_line)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_gap_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_tick(i_advance);
            if (o_valid && !i_stall)
                sb.check_pixel('{o_hsync_n, o_vsync_n, o_visible, o_column, o_line});
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic send_tick(input bit adv);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_advance <= adv;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic run_random(input int n_ticks);
        int k;
        for (k = 0; k < n_ticks; k++) send_tick($urandom_range(99) < 85);
    endtask

    // Drains every outstanding pixel, then allows the output stage to settle.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic program_timing(input t_vstg_cfg c);
        write_reg(CFG_H_VISIBLE, c.h_visible);
        write_reg(CFG_H_FRONT, c.h_front);
        write_reg(CFG_H_SYNC, c.h_sync);
        write_reg(CFG_H_BACK, c.h_back);
        write_reg(CFG_V_VISIBLE, c.v_visible);
        write_reg(CFG_V_FRONT, c.v_front);
        write_reg(CFG_V_SYNC, c.v_sync);
        write_reg(CFG_V_BACK, c.v_back);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly short segments so lines and frames wrap often, with zeros and
    // full-scale values mixed in.
    function automatic logic [REG_W-1:0] rand_len();
        int r;
        r = $urandom_range(99);
        if (r < 50) return REG_W'($urandom_range(4, 0));
        else if (r < 84) return REG_W'($urandom_range(24, 1));
        else if (r < 92) return '1;
        else return REG_W'($urandom_range(2047, 0));
    endfunction

    function automatic t_vstg_cfg random_timing();
        t_vstg_cfg c;
        c.h_visible = rand_len();
        c.h_front   = rand_len();
        c.h_sync    = rand_len();
        c.h_back    = rand_len();
        c.v_visible = rand_len();
        c.v_front   = rand_len();
        c.v_sync    = rand_len();
        c.v_back    = rand_len();
        return c;
    endfunction

    initial begin
        int ph;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_advance    = 1'b0;
        i_stall      = 1'b0;
        hold_left    = 0;
        stuck_cycles = 0;
        send_gap_pct = 21;
        recv_gap_pct = 72;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset timing, including held ticks.
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        repeat (5) send_tick(1'b1);

        // Shortest line and frame; the column already lies past the new period.
        settle();
        program_timing('{h_visible: 11'd1, h_front: 11'd0, h_sync: 11'd1, h_back: 11'd0,
                         v_visible: 11'd1, v_front: 11'd0, v_sync: 11'd1, v_back: 11'd0});
        repeat (6) send_tick(1'b1);

        // Zero period: no sync, no visible area, and every step returns the counters to zero.
        settle();
        program_timing('{default: '0});
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        // Full-scale registers; both periods are capped at the counter range.
        settle();
        program_timing('{default: '1});
        repeat (4) send_tick(1'b1);

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == RAND_PHASES / 3) begin
                send_gap_pct = 72;
                recv_gap_pct = 21;
            end else if (ph == 2 * RAND_PHASES / 3) begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            settle();
            program_timing(random_timing());
            // Long receiver hold-off while ticks keep coming, so the input backs up.
            if (ph == RAND_PHASES - 3) hold_left = 150;
            run_random(PHASE_TICKS);
        end

        settle();
        if (sb.fails == 0 && sb.pending_count() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
